// ----- rtl/core/sld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length/XOR frame deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned REG_IDXW = 2;

  // register map indexes (byte address = 4 * index)
  typedef enum logic [REG_IDXW-1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_t;

  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'h4C;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'h4D;
  localparam logic [BYTE_W-1:0] MAX_LEN_RST     = 8'd50;

  typedef struct packed {
    logic [BYTE_W-1:0] first_sync;
    logic [BYTE_W-1:0] second_sync;
    logic [BYTE_W-1:0] max_len;
  } cfg_t;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'b0001,
    PH_SYNC2   = 4'b0010,
    PH_LENGTH  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

endpackage

// ----- rtl/core/sync_length_xor_deframer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_unit
// Sync/length/XOR-check deframer for a received serial byte stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      tdata[7:0] = rx_byte
// out_     master     tdata = {byte_position, payload_byte}, tlast = is_last,
//                     tuser = check_ok
// cfg_     APB        0x0 first sync, 0x4 second sync, 0x8 max frame length
//
// One byte per cycle while in_tready is high; each accepted payload byte lands
// in the output register on the next edge, as the frame state registers do.
// Synchronous active-low reset returns to hunting with default register values.
// A stalled output holds in_tready low only while its register is full and
// out_tready is low; header bytes pass without producing an item.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,     // [7:0] rx_byte
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,    // [7:0] payload_byte, [15:8] byte_position
  output logic                       out_tlast,
  output logic                       out_tuser,    // [0] check_ok
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [sld_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [sld_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [sld_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  sld_pkg::cfg_t cfg;
  logic [sld_pkg::BYTE_W-1:0] pay_byte;
  logic [sld_pkg::BYTE_W-1:0] pay_pos;

  sld_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sld_deframer u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (pay_byte),
    .out_pos   (pay_pos),
    .out_last  (out_tlast),
    .out_ok    (out_tuser)
  );

  assign out_tdata = {pay_pos, pay_byte};

endmodule

// ----- rtl/core/sld_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_cfg_regs
// APB register bank: sync byte values and the frame length limit.
// ----------------------------------------------------------------------------
module sld_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sld_pkg::APB_AW-1:0]   paddr,
  input  logic [sld_pkg::APB_DW-1:0]   pwdata,
  output logic [sld_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output sld_pkg::cfg_t                cfg
);

  sld_pkg::cfg_t cfg_r;
  sld_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [sld_pkg::REG_IDXW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[sld_pkg::APB_AW-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        sld_pkg::REG_FIRST_SYNC:  cfg_nxt.first_sync  = pwdata[sld_pkg::BYTE_W-1:0];
        sld_pkg::REG_SECOND_SYNC: cfg_nxt.second_sync = pwdata[sld_pkg::BYTE_W-1:0];
        sld_pkg::REG_MAX_LEN:     cfg_nxt.max_len     = pwdata[sld_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sld_pkg::REG_FIRST_SYNC:
        prdata = {{(sld_pkg::APB_DW-sld_pkg::BYTE_W){1'b0}}, cfg_r.first_sync};
      sld_pkg::REG_SECOND_SYNC:
        prdata = {{(sld_pkg::APB_DW-sld_pkg::BYTE_W){1'b0}}, cfg_r.second_sync};
      sld_pkg::REG_MAX_LEN:
        prdata = {{(sld_pkg::APB_DW-sld_pkg::BYTE_W){1'b0}}, cfg_r.max_len};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_sync  <= sld_pkg::FIRST_SYNC_RST;
      cfg_r.second_sync <= sld_pkg::SECOND_SYNC_RST;
      cfg_r.max_len     <= sld_pkg::MAX_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/sld_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sld_deframer
// Frame state tracking per received byte, with a registered result stage.
// ----------------------------------------------------------------------------
module sld_deframer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sld_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [sld_pkg::BYTE_W-1:0] in_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sld_pkg::BYTE_W-1:0] out_byte,
  output logic [sld_pkg::BYTE_W-1:0] out_pos,
  output logic                       out_last,
  output logic                       out_ok
);

  sld_pkg::phase_t phase_r, phase_nxt;
  logic [sld_pkg::BYTE_W-1:0] len_r, len_nxt;
  logic [sld_pkg::BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [sld_pkg::BYTE_W-1:0] xor_r, xor_nxt;

  logic                       ovld_r, ovld_nxt;
  logic [sld_pkg::BYTE_W-1:0] obyte_r, opos_r;
  logic                       olast_r, ook_r;

  logic accept;
  logic emit;
  logic last;
  logic [sld_pkg::BYTE_W:0] cnt_inc;

  // output register frees up when downstream takes the held item
  assign in_ready = ~ovld_r | out_ready;
  assign accept   = in_valid & in_ready;
  assign emit     = accept & (phase_r == sld_pkg::PH_PAYLOAD);
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign last     = cnt_inc >= {1'b0, len_r};

  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    if (accept) begin
      case (phase_r)
        sld_pkg::PH_HUNT: begin
          if (in_byte == cfg.first_sync) phase_nxt = sld_pkg::PH_SYNC2;
        end
        sld_pkg::PH_SYNC2: begin
          // mismatch goes back to hunting without re-checking this byte
          phase_nxt = (in_byte == cfg.second_sync) ? sld_pkg::PH_LENGTH : sld_pkg::PH_HUNT;
        end
        sld_pkg::PH_LENGTH: begin
          if (in_byte == '0 || in_byte > cfg.max_len) begin
            phase_nxt = sld_pkg::PH_HUNT;
          end else begin
            len_nxt   = in_byte;
            cnt_nxt   = '0;
            xor_nxt   = '0;
            phase_nxt = sld_pkg::PH_PAYLOAD;
          end
        end
        sld_pkg::PH_PAYLOAD: begin
          if (last) begin
            phase_nxt = sld_pkg::PH_HUNT;
            cnt_nxt   = '0;
          end else begin
            xor_nxt = xor_r ^ in_byte;
            cnt_nxt = cnt_inc[sld_pkg::BYTE_W-1:0];
          end
        end
        default: phase_nxt = sld_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (emit)           ovld_nxt = 1'b1;
    else if (out_ready) ovld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= sld_pkg::PH_HUNT;
      len_r   <= '0;
      cnt_r   <= '0;
      xor_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r <= in_byte;
      opos_r  <= cnt_r;
      olast_r <= last;
      ook_r   <= last & (xor_r == in_byte);
    end
  end

  assign out_valid = ovld_r;
  assign out_byte  = obyte_r;
  assign out_pos   = opos_r;
  assign out_last  = olast_r;
  assign out_ok    = ook_r;

endmodule
